### hw/rtl/shmc_pkg.sv
package shmc_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_SENSING    = 2'd1,
        MODE_RUNNING    = 2'd2,
        MODE_SANITIZING = 2'd3
    } t_mode;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_DAY_START_HOUR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_END_HOUR        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_HEAT_ON_TEMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_HEAT_OFF_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SANITIZE_END_TEMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SANITIZE_INTERVAL_S = 3'd5;

    localparam logic [1:0] SENSE_LAST_TICK = 2'd2;

endpackage

### hw/rtl/solar_heater_mode_controller_core.sv
// Pipeline: an accepted item is held in the input register and then in the result
// register, from which it is valid on the output.
// Throughput: one item per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (synchronous, active low) restores the configuration defaults, puts
// the machine in night idle with pump and heater off, and empties the pipeline.
module solar_heater_mode_controller_core
    import shmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // hour[4:0], now_seconds[36:5], tank_temp[45:37], solar_temp[54:46], zero pad[55]
    input  logic [55:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pump_on[0], heater_on[1], mode_code[3:2], zero pad[7:4]
    output logic [7:0]            m_axis_tdata
);

    logic [4:0]         r_day_start_hour;
    logic [4:0]         r_day_end_hour;
    logic signed [8:0]  r_night_heat_on_temp;
    logic signed [8:0]  r_night_heat_off_temp;
    logic signed [8:0]  r_sanitize_end_temp;
    logic [19:0]        r_sanitize_interval_s;

    logic               r_in_valid;
    logic [4:0]         r_hour;
    logic [31:0]        r_now;
    logic signed [8:0]  r_tank;
    logic signed [8:0]  r_solar;

    t_mode              r_mode, n_mode;
    logic [1:0]         r_sense_ticks, n_sense_ticks;
    logic [31:0]        r_last_sanitize, n_last_sanitize;
    logic               r_pump, n_pump;
    logic               r_heater, n_heater;

    logic               r_out_valid;
    logic [7:0]         r_out_data;

    logic               advance;
    logic               is_day;
    logic               too_soon;
    logic               tank_hot;
    logic [31:0]        elapsed;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign is_day   = (r_hour >= r_day_start_hour) && (r_hour < r_day_end_hour);
    assign elapsed  = r_now - r_last_sanitize;
    assign too_soon = elapsed < {12'd0, r_sanitize_interval_s};
    assign tank_hot = r_tank >= r_sanitize_end_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day_start_hour      <= 5'd8;
            r_day_end_hour        <= 5'd18;
            r_night_heat_on_temp  <= 9'sd100;
            r_night_heat_off_temp <= 9'sd110;
            r_sanitize_end_temp   <= 9'sd140;
            r_sanitize_interval_s <= 20'd75600;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DAY_START_HOUR:      r_day_start_hour      <= i_cfg_data[4:0];
                CFG_DAY_END_HOUR:        r_day_end_hour        <= i_cfg_data[4:0];
                CFG_NIGHT_HEAT_ON_TEMP:  r_night_heat_on_temp  <= i_cfg_data[8:0];
                CFG_NIGHT_HEAT_OFF_TEMP: r_night_heat_off_temp <= i_cfg_data[8:0];
                CFG_SANITIZE_END_TEMP:   r_sanitize_end_temp   <= i_cfg_data[8:0];
                CFG_SANITIZE_INTERVAL_S: r_sanitize_interval_s <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Mode and sense counter.
    always_comb begin
        n_mode        = r_mode;
        n_sense_ticks = r_sense_ticks;
        case (r_mode)
            MODE_IDLE: begin
                if (is_day) begin
                    n_mode = MODE_RUNNING;
                end
            end
            MODE_SENSING: begin
                if (r_sense_ticks < SENSE_LAST_TICK) begin
                    n_sense_ticks = r_sense_ticks + 2'd1;
                end else begin
                    n_sense_ticks = 2'd0;
                    n_mode        = MODE_RUNNING;
                end
            end
            MODE_RUNNING: begin
                if (!is_day) begin
                    n_mode = MODE_SANITIZING;
                end else if (r_solar > r_tank) begin
                    n_mode = MODE_SENSING;
                end
            end
            MODE_SANITIZING: begin
                if (too_soon || tank_hot) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: n_mode = MODE_IDLE;
        endcase
    end

    // Pump, heater and sanitize time stamp.
    always_comb begin
        n_pump          = r_pump;
        n_heater        = r_heater;
        n_last_sanitize = r_last_sanitize;
        case (r_mode)
            MODE_IDLE: begin
                if (!is_day) begin
                    if (r_heater) begin
                        if (r_tank > r_night_heat_off_temp) begin
                            n_heater = 1'b0;
                        end
                    end else if (r_tank < r_night_heat_on_temp) begin
                        n_heater = 1'b1;
                    end
                end
            end
            MODE_SENSING: begin
                n_pump = 1'b1;
            end
            MODE_RUNNING: begin
                n_heater = 1'b0;
                if (is_day && !(r_solar > r_tank)) begin
                    n_pump = 1'b0;
                end
            end
            MODE_SANITIZING: begin
                if (!too_soon && !tank_hot) begin
                    n_heater = 1'b1;
                end
            end
            default: ;
        endcase
        if (tank_hot) begin
            n_last_sanitize = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_mode          <= MODE_IDLE;
            r_sense_ticks   <= 2'd0;
            r_last_sanitize <= 32'd0;
            r_pump          <= 1'b0;
            r_heater        <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_mode          <= n_mode;
                    r_sense_ticks   <= n_sense_ticks;
                    r_last_sanitize <= n_last_sanitize;
                    r_pump          <= n_pump;
                    r_heater        <= n_heater;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_hour  <= s_axis_tdata[4:0];
            r_now   <= s_axis_tdata[36:5];
            r_tank  <= s_axis_tdata[45:37];
            r_solar <= s_axis_tdata[54:46];
        end
        if (advance && r_in_valid) begin
            r_out_data <= {4'd0, n_mode, n_heater, n_pump};
        end
    end

endmodule
